>>> hw/rtl/aesr_pkg.sv
// ----------------------------------------------------------------------------
// aesr_pkg - shared types and functions for the AES encryption round
// Holds the state type, the S-box and the GF(2^8) helpers for the datapath.
// ----------------------------------------------------------------------------
package aesr_pkg;

  localparam int unsigned HALF_W  = 64;
  localparam int unsigned NBYTES  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] GF_POLY = 8'h1b;

  // byte 0 is the leftmost element, so it lands in the top bits when packed
  typedef logic [0:NBYTES-1][7:0] state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    logic [7:0] r;
    r = {b[6:0], 1'b0};
    if (b[7]) begin
      r = r ^ GF_POLY;
    end
    return r;
  endfunction

  // SubBytes then ShiftRows: row r of column c takes row r of column c+r
  function automatic state_t sub_shift(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4 + r] = SBOX[s[((c + r) % 4)*4 + r]];
      end
    end
    return t;
  endfunction

  function automatic state_t column_mix(input state_t t);
    state_t     s;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4];
      a1 = t[c*4 + 1];
      a2 = t[c*4 + 2];
      a3 = t[c*4 + 3];
      s[c*4]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      s[c*4 + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      s[c*4 + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      s[c*4 + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return s;
  endfunction

endpackage

>>> hw/rtl/aesr_in_if.sv
// ----------------------------------------------------------------------------
// aesr_in_if - input channel of the AES encryption round
// Valid/ready channel carrying one state block and its round flags.
// ----------------------------------------------------------------------------
interface aesr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        pre_whiten;
  logic        last_round;

  modport source (output valid, block_high, block_low, pre_whiten, last_round,
                  input ready);
  modport sink   (input valid, block_high, block_low, pre_whiten, last_round,
                  output ready);
endinterface

>>> hw/rtl/aesr_out_if.sv
// ----------------------------------------------------------------------------
// aesr_out_if - result channel of the AES encryption round
// Valid/ready channel carrying one result state block.
// ----------------------------------------------------------------------------
interface aesr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;

  modport source (output valid, out_high, out_low, input ready);
  modport sink   (input valid, out_high, out_low, output ready);
endinterface

>>> hw/rtl/aes_encrypt_round.sv
// ----------------------------------------------------------------------------
// aes_encrypt_round - one AES-128 encryption round, three-stage pipeline
// Optional whitening, SubBytes, ShiftRows, MixColumns if not last, AddRoundKey.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one 128-bit state per beat (block_high holds bytes 0..7,
//          byte 0 in the top bits) with the pre_whiten and last_round flags.
//   out_ch returns the round result as out_high / out_low, one beat per item.
//   cfg_*  writes the round key: index REG_KEY_HIGH for key bytes 0..7,
//          REG_KEY_LOW for bytes 8..15. Write it only while the pipe is empty.
// Pipeline: an accepted item passes stage 1 whiten, stage 2
//   SubBytes/ShiftRows and stage 3 MixColumns/AddRoundKey into the output
//   register, from which out_ch offers it.
// Throughput: one beat per cycle unless out_ch stalls; one item per stage.
// Reset: synchronous, active low; empties all stages and clears the key.
// Stall: when out_ch.ready is low the output stage holds; earlier stages
//   keep moving until they run into a full stage, so up to three items sit
//   in the pipe before in_ch.ready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module aes_encrypt_round
  import aesr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  aesr_in_if.sink              in_ch,
  aesr_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [HALF_W-1:0]    cfg_wdata
);

  // round key, held in configuration
  logic [HALF_W-1:0] key_hi_r, key_lo_r;
  state_t            key;

  // stage valids and payloads
  logic   v1_r, v2_r, v3_r;
  logic   last1_r, last2_r;
  state_t s1_r, s2_r, s3_r;
  state_t s1_nxt, s2_nxt, s3_nxt;

  // stage enables: a stage loads when it is empty or its contents move on
  logic en1, en2, en3;

  assign key = {key_hi_r, key_lo_r};

  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;

  // stage 1: optional whitening with the round key
  always_comb begin
    s1_nxt = {in_ch.block_high, in_ch.block_low};
    if (in_ch.pre_whiten) begin
      s1_nxt = s1_nxt ^ key;
    end
  end

  // stage 2: SubBytes and ShiftRows
  assign s2_nxt = sub_shift(s1_r);

  // stage 3: MixColumns unless this is the final round, then AddRoundKey
  always_comb begin
    if (last2_r) begin
      s3_nxt = s2_r ^ key;
    end else begin
      s3_nxt = column_mix(s2_r) ^ key;
    end
  end

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY_HIGH: key_hi_r <= cfg_wdata;
        REG_KEY_LOW:  key_lo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // payload: load on enable, hold while stalled
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r    <= s1_nxt;
      last1_r <= in_ch.last_round;
    end
    if (en2) begin
      s2_r    <= s2_nxt;
      last2_r <= last1_r;
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_ch.valid    = v3_r;
  assign out_ch.out_high = s3_r[0:7];
  assign out_ch.out_low  = s3_r[8:15];

endmodule

>>> hw/rtl/aesr_chk.sv
// ----------------------------------------------------------------------------
// aesr_chk - port-level checks for the AES encryption round
// Tracks beats in flight and checks output handshake and flow behaviour.
// ----------------------------------------------------------------------------
module aesr_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  logic       in_fire, out_fire;
  logic [2:0] cnt_r, cnt_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire && !out_fire) begin
      cnt_nxt = cnt_r + 3'd1;
    end else if (out_fire && !in_fire) begin
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output stage");

  // no result without an item in flight
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("result with nothing in flight");

  // three stages hold at most three items
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd3)
    else $error("more items in flight than stages");

endmodule

bind aes_encrypt_round aesr_chk u_aesr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
